>>> src/base64_stream_decoder_top_defines.svh
// -----------------------------------------------------------------------------
// Base64 stream decoder assertion macros
// Shared concurrent assertion forms for the decoder checker.
// -----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_TOP_DEFINES_SVH
`define BASE64_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64D_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("decoder assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define B64D_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("decoder assertion failed");

`endif

>>> src/b64d_pkg.sv
// -----------------------------------------------------------------------------
// Base64 decoder package
// Status codes, register indexes, result types and the alphabet lookup.
// -----------------------------------------------------------------------------
package b64d_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_LONE     = 2'd2,
    ST_INVALID  = 2'd3
  } b64d_status_e;

  localparam logic CFG_IGNORE_PADDING = 1'b0;
  localparam logic CFG_IGNORE_ERRORS  = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef struct packed {
    logic [7:0]   data_byte;
    logic         byte_valid;
    logic         end_of_stream;
    b64d_status_e status;
  } b64d_res_t;

  typedef struct packed {
    logic [1:0]           count;
    b64d_res_t [2:0]      res;
  } b64d_push_t;

  // Returns {invalid, value}; the value is zero for an invalid character.
  function automatic logic [6:0] b64d_sym(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
      return {1'b0, t[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h47;
      return {1'b0, t[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c + 8'h04;
      return {1'b0, t[5:0]};
    end else if (c == 8'h2B) begin
      return {1'b0, 6'h3E};
    end else if (c == 8'h2F) begin
      return {1'b0, 6'h3F};
    end
    return {1'b1, t[5:0]};
  endfunction

endpackage

>>> src/base64_stream_decoder_top.sv
// -----------------------------------------------------------------------------
// Base64 stream decoder
// Decodes one base64 character per cycle, while the queue has room, into bytes with end-of-stream status.
//
//   Channel   Signals                                        Direction
//   input     char_code_i, last_char_i, in_valid_i/ready_o   in
//   output    data_byte_o, byte_valid_o, end_of_stream_o,
//             status_o, out_valid_o/out_ready_i              out
//   config    cfg_we_i, cfg_index_i, cfg_wdata_i             in
//
// One character is taken per cycle while the queue has room; its results enter the queue at that edge
// and, if the queue was empty, the first of them is offered in the next cycle.
// Results leave the queue at one per cycle while out_ready_i is high.
// Input is accepted while the queue has room for three more results.
// Reset clears the quartet position, the error flag, the queue and the config.
// -----------------------------------------------------------------------------
module base64_stream_decoder_top
  import b64d_pkg::*;
#(
  parameter int FifoDepth = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic       cfg_wdata_i,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic       end_of_stream_o,
  output logic [1:0] status_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  logic       ign_pad_q, ign_err_q;
  logic       accept;
  b64d_push_t push;
  b64d_res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ign_pad_q <= 1'b0;
      ign_err_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IGNORE_PADDING: ign_pad_q <= cfg_wdata_i;
        CFG_IGNORE_ERRORS:  ign_err_q <= cfg_wdata_i;
        default:            ign_pad_q <= ign_pad_q;
      endcase
    end
  end

  assign accept = in_valid_i && in_ready_o;

  b64d_decode u_decode (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .char_code_i      (char_code_i),
    .last_char_i      (last_char_i),
    .ignore_padding_i (ign_pad_q),
    .ignore_errors_i  (ign_err_q),
    .push_o           (push)
  );

  b64d_out_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (res)
  );

  assign data_byte_o     = res.data_byte;
  assign byte_valid_o    = res.byte_valid;
  assign end_of_stream_o = res.end_of_stream;
  assign status_o        = res.status;

endmodule

>>> src/b64d_decode.sv
// -----------------------------------------------------------------------------
// Base64 decoder quartet logic
// Holds the partial quartet and turns the fourth or last character of each quartet into results.
// -----------------------------------------------------------------------------
module b64d_decode
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  input  logic       ignore_padding_i,
  input  logic       ignore_errors_i,
  output b64d_push_t push_o
);

  logic [7:0]    held_q [3];
  logic [1:0]    pos_q, pos_d;
  logic          inv_q, inv_d;

  logic [3:0][7:0] q;
  logic [3:0][5:0] v;
  logic [3:0]      bad;
  logic [3:0]      dec;
  logic [1:0]      nb;
  logic            inv_now;
  logic [2:0][7:0] b;
  b64d_status_e    status;

  always_comb begin
    logic [6:0] s;
    q[0] = held_q[0];
    q[1] = held_q[1];
    q[2] = held_q[2];
    q[3] = char_code_i;
    if (last_char_i) begin
      q[pos_q] = char_code_i;
    end
    for (int i = 0; i < 4; i++) begin
      s      = b64d_sym(q[i]);
      bad[i] = s[6] | q[i][7];
      v[i]   = 6'h00;
      dec[i] = 1'b0;
    end

    nb = 2'd0;
    if (!last_char_i) begin
      if (pos_q == 2'd3) begin
        nb = 2'd3;
      end
    end else begin
      case (pos_q)
        2'd3: begin
          nb = 2'd3;
          if (char_code_i == PAD_CHAR) begin
            nb = (held_q[2] == PAD_CHAR) ? 2'd1 : 2'd2;
          end
        end
        2'd2, 2'd1: begin
          nb = ignore_padding_i ? pos_q : 2'd0;
        end
        default: begin
          nb = 2'd0;
        end
      endcase
    end

    case (nb)
      2'd3:    dec = 4'hF;
      2'd2:    dec = 4'h7;
      2'd1:    dec = 4'h3;
      default: dec = 4'h0;
    endcase

    for (int i = 0; i < 4; i++) begin
      s = b64d_sym(q[i]);
      if (dec[i] && !bad[i]) begin
        v[i] = s[5:0];
      end
    end
    inv_now = inv_q | (|(dec & bad));

    b[0] = {v[0], v[1][5:4]};
    b[1] = {v[1][3:0], v[2][5:2]};
    b[2] = {v[2][1:0], v[3]};

    status = ST_OK;
    if (pos_q != 2'd3) begin
      if (!ignore_padding_i) begin
        status = ST_BAD_LEN;
      end else if (pos_q == 2'd0 && !ignore_errors_i) begin
        status = ST_LONE;
      end
    end
    if (status == ST_OK && inv_now && !ignore_errors_i) begin
      status = ST_INVALID;
    end

    push_o.count = 2'd0;
    for (int k = 0; k < 3; k++) begin
      push_o.res[k].data_byte     = b[k];
      push_o.res[k].byte_valid    = 1'b1;
      push_o.res[k].end_of_stream = last_char_i && (2'(k) == nb - 2'd1);
      push_o.res[k].status        = (last_char_i && (2'(k) == nb - 2'd1)) ? status : ST_OK;
    end
    if (last_char_i && nb == 2'd0) begin
      push_o.res[0].data_byte     = 8'h00;
      push_o.res[0].byte_valid    = 1'b0;
      push_o.res[0].end_of_stream = 1'b1;
      push_o.res[0].status        = status;
    end
    if (accept_i) begin
      push_o.count = (last_char_i && nb == 2'd0) ? 2'd1 : nb;
    end

    pos_d = pos_q;
    inv_d = inv_q;
    if (accept_i) begin
      if (last_char_i) begin
        pos_d = 2'd0;
        inv_d = 1'b0;
      end else begin
        pos_d = pos_q + 2'd1;
        inv_d = inv_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
      inv_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      inv_q <= inv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !last_char_i && pos_q != 2'd3) begin
      held_q[pos_q] <= char_code_i;
    end
  end

endmodule

>>> src/b64d_out_fifo.sv
// -----------------------------------------------------------------------------
// Base64 decoder result queue
// Takes up to three results per cycle and delivers one per cycle while out_ready_i is high.
// -----------------------------------------------------------------------------
module b64d_out_fifo
  import b64d_pkg::*;
#(
  parameter int Depth = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  b64d_push_t push_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output b64d_res_t  out_res_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  b64d_res_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] widx [3];
  logic            pop;

  function automatic logic [PtrW-1:0] wrap_add(input logic [PtrW-1:0] p,
                                               input logic [1:0] k);
    logic [PtrW:0] s;
    s = {1'b0, p} + (PtrW + 1)'(k);
    if (s >= (PtrW + 1)'(Depth)) begin
      s = s - (PtrW + 1)'(Depth);
    end
    return s[PtrW-1:0];
  endfunction

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = mem_q[rd_q];
  assign room_o      = (cnt_q <= CntW'(Depth - 3));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      widx[k] = wrap_add(wr_q, 2'(k));
    end
    wr_d  = wrap_add(wr_q, push_i.count);
    rd_d  = pop ? wrap_add(rd_q, 2'd1) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push_i.count) begin
        mem_q[widx[k]] <= push_i.res[k];
      end
    end
  end

endmodule

>>> src/b64d_checker.sv
// -----------------------------------------------------------------------------
// Base64 decoder port checker
// Watches the result channel of the decoder top level.
// -----------------------------------------------------------------------------
`include "base64_stream_decoder_top_defines.svh"

module b64d_checker
  import b64d_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic [7:0] data_byte_o,
  input logic       byte_valid_o,
  input logic       end_of_stream_o,
  input logic [1:0] status_o,
  input logic       out_valid_o,
  input logic       out_ready_i
);

  logic        out_stall;
  logic        out_empty;
  logic        out_mid;
  logic [11:0] out_payload;

  assign out_stall   = out_valid_o && !out_ready_i;
  assign out_empty   = out_valid_o && !byte_valid_o;
  assign out_mid     = out_valid_o && !end_of_stream_o;
  assign out_payload = {data_byte_o, byte_valid_o, end_of_stream_o, status_o};

  // A stalled item holds.
  `B64D_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_payload))
  // An item without a byte closes a stream.
  `B64D_ASSERT_IMP(a_status_only_eos, clk_i, rst_ni, out_empty, end_of_stream_o)
  // Status is reported only at the end of a stream.
  `B64D_ASSERT_IMP(a_status_at_end, clk_i, rst_ni, out_mid, status_o == ST_OK)
  // An item without a byte carries a zero byte.
  `B64D_ASSERT_IMP(a_empty_byte_zero, clk_i, rst_ni, out_empty, data_byte_o == 8'h00)

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .data_byte_o     (data_byte_o),
  .byte_valid_o    (byte_valid_o),
  .end_of_stream_o (end_of_stream_o),
  .status_o        (status_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i)
);

>>> tb/sv/tb_base64_stream_decoder_top.sv
// -----------------------------------------------------------------------------
// Base64 stream decoder testbench
// Feeds directed and random character streams through the decoder under every
// register setting, predicts the decoded bytes and end-of-stream status of each
// accepted item, and checks every result item in order against the prediction.
// Both handshake sides idle and stall at random, apart from one calm pass.
// -----------------------------------------------------------------------------
module tb_base64_stream_decoder_top;
  import b64d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  class b64_scoreboard;
    b64d_res_t  expected_q[$];
    logic [7:0] quartet[3];
    logic [1:0] fill;
    logic       bad_char_seen;
    logic       ign_pad;
    logic       ign_err;
    int         errors;

    function new();
      quartet = '{8'h00, 8'h00, 8'h00};
      fill = 2'd0;
      bad_char_seen = 1'b0;
      ign_pad = 1'b0;
      ign_err = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic val);
      if (idx == CFG_IGNORE_PADDING) begin
        ign_pad = val;
      end else begin
        ign_err = val;
      end
    endfunction

    function logic [5:0] sextet(logic [7:0] c);
      if (c >= "A" && c <= "Z") return 6'(c - "A");
      if (c >= "a" && c <= "z") return 6'(c - "a" + 26);
      if (c >= "0" && c <= "9") return 6'(c - "0" + 52);
      if (c == "+") return 6'd62;
      if (c == "/") return 6'd63;
      bad_char_seen = 1'b1;
      return 6'd0;
    endfunction

    function void decode_group(logic [3:0][7:0] q, int nb);
      logic [23:0] w;
      b64d_res_t   r;
      int          i;
      w = '0;
      for (i = 0; i <= nb && i < 4; i++) begin
        w = w | (24'(sextet(q[i])) << (18 - 6 * i));
      end
      for (i = 0; i < nb; i++) begin
        r.data_byte = w[23 - 8 * i -: 8];
        r.byte_valid = 1'b1;
        r.end_of_stream = 1'b0;
        r.status = ST_OK;
        expected_q.push_back(r);
      end
    endfunction

    function void note_char(logic [7:0] c, logic last);
      logic [3:0][7:0] q;
      b64d_status_e    st;
      b64d_res_t       r;
      int              nb;
      q = {8'h00, quartet[2], quartet[1], quartet[0]};
      q[fill] = c;
      if (!last) begin
        if (fill < 2'd3) begin
          quartet[fill] = c;
          fill = fill + 2'd1;
        end else begin
          decode_group(q, 3);
          fill = 2'd0;
        end
        return;
      end
      nb = 0;
      st = ST_OK;
      if (fill == 2'd3) begin
        nb = 3;
        if (c == PAD_CHAR) begin
          nb = (quartet[2] == PAD_CHAR) ? 1 : 2;
        end
      end else if (!ign_pad) begin
        st = ST_BAD_LEN;
      end else if (fill == 2'd0) begin
        if (!ign_err) st = ST_LONE;
      end else begin
        nb = fill;
      end
      decode_group(q, nb);
      if (st == ST_OK && bad_char_seen && !ign_err) st = ST_INVALID;
      if (nb == 0) begin
        r.data_byte = 8'h00;
        r.byte_valid = 1'b0;
      end else begin
        r = expected_q.pop_back();
      end
      r.end_of_stream = 1'b1;
      r.status = st;
      expected_q.push_back(r);
      fill = 2'd0;
      bad_char_seen = 1'b0;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(b64d_res_t got);
      b64d_res_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result item, data_byte %02h", got.data_byte));
        return;
      end
      want = expected_q.pop_front();
      if (got.data_byte !== want.data_byte)
        report($sformatf("data_byte %02h, expected %02h", got.data_byte, want.data_byte));
      if (got.byte_valid !== want.byte_valid)
        report($sformatf("byte_valid %0b, expected %0b", got.byte_valid, want.byte_valid));
      if (got.end_of_stream !== want.end_of_stream)
        report($sformatf("end_of_stream %0b, expected %0b",
                         got.end_of_stream, want.end_of_stream));
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_index_i = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic [7:0] char_code_i = 8'h00;
  logic       last_char_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_o;
  logic       byte_valid_o;
  logic       end_of_stream_o;
  logic [1:0] status_o;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;

  logic          calm = 1'b0;
  int            chars_sent = 0;
  b64_scoreboard sb = new();

  base64_stream_decoder_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .char_code_i    (char_code_i),
    .last_char_i    (last_char_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_o    (data_byte_o),
    .byte_valid_o   (byte_valid_o),
    .end_of_stream_o(end_of_stream_o),
    .status_o       (status_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

  always #5ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 38);
  end

  always @(posedge clk_i) begin
    b64d_res_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.data_byte = data_byte_o;
      got.byte_valid = byte_valid_o;
      got.end_of_stream = end_of_stream_o;
      got.status = b64d_status_e'(status_o);
      sb.check_result(got);
    end
  end

  function automatic logic [7:0] b64_char(int idx);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    return (idx == 62) ? 8'h2B : 8'h2F;
  endfunction

  function automatic logic [7:0] rough_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return PAD_CHAR;
    if (r < 10) return 8'($urandom_range(0, 255));
    return b64_char($urandom_range(0, 63));
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(0, 99) < 38) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_code_i <= c;
    last_char_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_char(c, last);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic drain(input int quiet);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (quiet) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic pad, input logic err);
    drain(4);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_IGNORE_PADDING;
    cfg_wdata_i <= pad;
    @(posedge clk_i);
    cfg_index_i <= CFG_IGNORE_ERRORS;
    cfg_wdata_i <= err;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(CFG_IGNORE_PADDING, pad);
    sb.set_reg(CFG_IGNORE_ERRORS, err);
  endtask

  task automatic send_random_stream();
    int kind;
    int nq;
    int pad;
    int len;
    int i;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      nq = ($urandom_range(0, 9) == 0) ? 6 : $urandom_range(1, 3);
      pad = $urandom_range(0, 2);
      len = 4 * nq;
      for (i = 0; i < len; i++) begin
        c = (i >= len - pad) ? PAD_CHAR : b64_char($urandom_range(0, 63));
        send_char(c, i == len - 1);
      end
    end else if (kind < 85) begin
      len = 4 * $urandom_range(0, 2) + $urandom_range(1, 3);
      for (i = 0; i < len; i++) send_char(rough_char(), i == len - 1);
    end else begin
      len = $urandom_range(1, 9);
      for (i = 0; i < len; i++) send_char(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  initial begin
    int   p;
    int   start;
    logic paused;
    paused = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    program_regs(1'b0, 1'b0);
    send_text("+/Az09TQ==");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(PAD_CHAR, 1'b1);
    send_text("AB");

    program_regs(1'b1, 1'b0);
    send_text("Q");
    send_text("A=");
    send_text("ABC");

    program_regs(1'b0, 1'b1);
    send_char("T", 1'b0);
    send_char("W", 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(PAD_CHAR, 1'b1);

    program_regs(1'b1, 1'b1);
    send_text("Z");

    for (p = 0; p < 8; p++) begin
      if (p < 4) begin
        program_regs(p[0], p[1]);
      end else begin
        program_regs(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      calm <= (p == 5);
      start = chars_sent;
      while (chars_sent - start < 45) begin
        send_random_stream();
        if (p == 2 && !paused && chars_sent - start > 25) begin
          drain(0);
          paused = 1'b1;
        end
      end
    end

    drain(10);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("base64_stream_decoder_top verification clean");
    end else begin
      $display("base64_stream_decoder_top verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("base64_stream_decoder_top verification failed");
    $finish;
  end

endmodule

>>> base64_stream_decoder_top.f
+incdir+src
src/b64d_pkg.sv
src/b64d_decode.sv
src/b64d_out_fifo.sv
src/base64_stream_decoder_top.sv
src/b64d_checker.sv
tb/sv/tb_base64_stream_decoder_top.sv
